FILE: src/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// shared types and constants of the trigger time track
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned TTS_DEPTH = 64;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 64;

  // register select, taken from the address bit above the byte offset
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_UPD = 2'd1,
    OP_CLR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_ADV_RD,
    S_ADV_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] range_low;
    logic [TIME_W-1:0] range_high;
  } cfg_t;

endpackage

FILE: src/tts_cfg.sv
// ----------------------------------------------------------------------------
// tts_cfg
// apb register file holding the inclusive update time range
// ----------------------------------------------------------------------------
module tts_cfg
  import tts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [TIME_W-1:0] range_low_q, range_low_d;
  logic [TIME_W-1:0] range_high_q, range_high_d;
  logic              wr_en;
  logic              sel;

  // bits below bit 3 are the byte offset within a register
  assign sel    = paddr[3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    range_low_d  = range_low_q;
    range_high_d = range_high_q;
    if (wr_en) begin
      if (sel == REG_RANGE_LOW) begin
        range_low_d = pwdata;
      end else begin
        range_high_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '1;
    end else begin
      range_low_q  <= range_low_d;
      range_high_q <= range_high_d;
    end
  end

  assign prdata = (sel == REG_RANGE_LOW) ? range_low_q : range_high_q;

  assign cfg_o.range_low  = range_low_q;
  assign cfg_o.range_high = range_high_q;

  // low address bits only select a byte lane
  logic unused_addr;
  assign unused_addr = ^paddr[2:0];

endmodule

FILE: src/tts_core.sv
// ----------------------------------------------------------------------------
// tts_core
// key store memory with a read-modify-write sequencer for add, update, clear
// ----------------------------------------------------------------------------
module tts_core
  import tts_pkg::*;
#(
  parameter int unsigned DEPTH = TTS_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TIME_W-1:0] s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [TIME_W-1:0] mem_q [DEPTH];
  logic [TIME_W-1:0] rdata_q;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [TIME_W-1:0] wdata;
  logic              we;

  op_e               op_q, op_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     sh_q, sh_d;
  logic [CW-1:0]     sh_dec;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              trig_q, trig_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic              out_trig_q, out_trig_d;
  status_e           out_status_q, out_status_d;

  logic in_fire;
  logic out_free;
  logic out_rng;
  logic full;
  logic srch_done;
  logic srch_eq;
  logic adv_end;
  logic adv_pass;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign out_rng       = (t_q < cfg_i.range_low) | (t_q > cfg_i.range_high);
  assign full          = (count_q == CW'(DEPTH));
  assign sh_dec        = sh_q - 1'b1;
  assign srch_done     = ((state_q == S_SRCH_RD) && (idx_q == count_q)) ||
                         ((state_q == S_SRCH_CMP) && (rdata_q >= t_q));
  assign srch_eq       = (state_q == S_SRCH_CMP) && (rdata_q == t_q);
  assign adv_end       = (cursor_q >= count_q);
  assign adv_pass      = (rdata_q <= t_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DISP;
      end
      S_DISP: begin
        case (op_q)
          OP_ADD: state_d = S_SRCH_RD;
          OP_UPD: begin
            if (out_rng || (last_q == t_q)) state_d = S_DONE;
            else if (last_q > t_q)           state_d = S_SRCH_RD;
            else                             state_d = S_ADV_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SRCH_RD, S_SRCH_CMP: begin
        if (srch_done) begin
          if (op_q == OP_ADD) begin
            state_d = (srch_eq || full) ? S_DONE : S_SH_RD;
          end else begin
            state_d = S_ADV_RD;
          end
        end else begin
          state_d = (state_q == S_SRCH_RD) ? S_SRCH_CMP : S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        state_d = (sh_q == idx_q) ? S_INS : S_SH_WR;
      end
      S_SH_WR:   state_d = S_SH_RD;
      S_INS:     state_d = S_DONE;
      S_ADV_RD:  state_d = adv_end ? S_DONE : S_ADV_CMP;
      S_ADV_CMP: state_d = adv_pass ? S_ADV_RD : S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d         = op_q;
    t_d          = t_q;
    idx_d        = idx_q;
    sh_d         = sh_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    last_d       = last_q;
    trig_d       = trig_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_trig_d   = out_trig_q;
    out_status_d = out_status_q;
    raddr        = idx_q[AW-1:0];
    waddr        = sh_q[AW-1:0];
    wdata        = rdata_q;
    we           = 1'b0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = op_e'(s_axis_tuser);
          t_d      = s_axis_tdata;
          trig_d   = 1'b0;
          status_d = STAT_OK;
        end
      end
      S_DISP: begin
        idx_d = '0;
        case (op_q)
          OP_UPD: begin
            if (out_rng) last_d = t_q;
          end
          OP_CLR:  count_d = '0;
          default: ;
        endcase
      end
      S_SRCH_RD, S_SRCH_CMP: begin
        if (srch_done) begin
          if (op_q == OP_ADD) begin
            if (srch_eq)   status_d = STAT_DUP;
            else if (full) status_d = STAT_FULL;
            else           sh_d     = count_q;
          end else begin
            cursor_d = idx_q;
          end
        end else if (state_q == S_SRCH_CMP) begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SH_RD: begin
        raddr = sh_dec[AW-1:0];
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = sh_q[AW-1:0];
        wdata = rdata_q;
        sh_d  = sh_dec;
      end
      S_INS: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        wdata   = t_q;
        count_d = count_q + 1'b1;
      end
      S_ADV_RD: begin
        raddr = cursor_q[AW-1:0];
        if (adv_end) last_d = t_q;
      end
      S_ADV_CMP: begin
        if (adv_pass) begin
          trig_d   = 1'b1;
          cursor_d = cursor_q + 1'b1;
        end else begin
          last_d = t_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_trig_d   = trig_q;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      last_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    t_q          <= t_d;
    idx_q        <= idx_d;
    sh_q         <= sh_d;
    trig_q       <= trig_d;
    status_q     <= status_d;
    out_trig_q   <= out_trig_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_status_q, out_trig_q};

endmodule

FILE: src/trigger_time_track.sv
// ----------------------------------------------------------------------------
// trigger_time_track
// sorted store of trigger times with a playback cursor
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata key_time, tuser op
//   m_axis    out  m_axis_tvalid/tready      tdata triggered, status
//   apb       in   psel/penable, pready=1    range_low @0x0, range_high @0x8
//
// one item at a time; keys are walked in the key memory, which has one read
// and one write port, each key being read, then compared or moved
// add: search the keys in order for the first key not below the new key;
// unless that key equals it or the store is full, the keys from there up
// move one place up and the new key is written in the gap
// update: walk the cursor over the keys not above the new time, setting
// triggered; a backward jump first rescans from the start for the first key
// not below the new time and puts the cursor there
// clear, out-of-range and repeated updates go straight to the result
// reset clears count and cursor and sets the last time to all ones; the key
// memory is not cleared; a new item is taken while the previous result waits
// in the output register
module trigger_time_track
  import tts_pkg::*;
#(
  parameter int unsigned DEPTH = TTS_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // key_time
  input  logic [1:0]        s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // triggered, status[2:1], zero fill
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  tts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tts_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
